FILE: sv/mbsb_pkg.sv
`default_nettype none
package mbsb_pkg;
  localparam int STORE_BYTES_D = 2048;
  localparam int MAX_PITCH_D = 64;
  localparam int PITCH_W = 7;
  localparam int ADDR_W = 11;

  localparam logic [1:0] OP_LOAD_SRC = 2'd0;
  localparam logic [1:0] OP_LOAD_DST = 2'd1;
  localparam logic [1:0] OP_READ_DST = 2'd2;
  localparam logic [1:0] OP_STENCIL = 2'd3;

  localparam logic CFG_SRC_PITCH = 1'b0;
  localparam logic CFG_DST_PITCH = 1'b1;
endpackage
`default_nettype wire

FILE: sv/masked_bitmap_stencil_blit.sv
// masked 1bpp stencil blit with local pattern, mask and destination stores
// input channel: in_valid / in_stall, one word per operation; result channel:
// out_valid / out_stall, exactly one result word per input word, in order
// config: cfg_we / cfg_index / cfg_data write source_pitch (0) and dest_pitch (1)
// loads pass the simple and done states; an in-range read also passes rdwait
// a stencil runs a sequencer with one shared multiply-add: three setup
// states for the fit test, then per row a row-address state and per covered
// pixel a fetch state and a merge state; a flagged or empty rectangle goes
// from the fit test straight to the done state
// the stores are single ported; a pixel update takes a fetch and a merge state
// in_stall is high while an item is in work and while a result waits
// the next input word is accepted only after the result is taken and the
// sequencer has gone from the done state back to idle
// reset clears the sequencer and the result valid and sets both pitches to 64;
// store contents stay undefined until written
// a stalled result holds unchanged until taken
`default_nettype none
module masked_bitmap_stencil_blit #(
  parameter int STORE_BYTES = mbsb_pkg::STORE_BYTES_D,
  parameter int MAX_PITCH = mbsb_pkg::MAX_PITCH_D
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [6:0] cfg_data,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] in_operation,
  input wire logic [10:0] in_address,
  input wire logic [7:0] in_pattern_byte,
  input wire logic [7:0] in_mask_byte,
  input wire logic [7:0] in_dest_byte_in,
  input wire logic [8:0] in_from_x,
  input wire logic [7:0] in_from_y,
  input wire logic [8:0] in_to_x,
  input wire logic [7:0] in_to_y,
  input wire logic [9:0] in_rect_width,
  input wire logic [8:0] in_rect_height,
  input wire logic in_reverse_video,
  output logic out_valid,
  input wire logic out_stall,
  output logic [7:0] out_read_data,
  output logic out_status
);
  import mbsb_pkg::*;
  localparam int SA_W = $clog2(STORE_BYTES);
  localparam int CW = 24;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_FIT1 = 4'd3;
  localparam logic [3:0] S_FIT2 = 4'd4;
  localparam logic [3:0] S_FIT3 = 4'd5;
  localparam logic [3:0] S_ROWS = 4'd6;
  localparam logic [3:0] S_FETCH = 4'd7;
  localparam logic [3:0] S_MERGE = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [PITCH_W-1:0] sp_cfg_r, dp_cfg_r;
  logic [1:0] op_r;
  logic [10:0] addr_r;
  logic [7:0] pat_r, msk_r, din_r;
  logic [8:0] fx_r, tx_r;
  logic [7:0] fy_r, ty_r;
  logic [9:0] w_r, c_r;
  logic [8:0] h_r, r_r;
  logic inv_r;
  logic bad_r;
  logic [CW-1:0] srow_r;
  logic [CW-1:0] sa_cur, da_cur;
  logic [2:0] sbit, dbit;
  logic out_valid_r;
  logic [7:0] out_data_r;
  logic out_status_r;

  logic [7:0] pat_mem [STORE_BYTES];
  logic [7:0] msk_mem [STORE_BYTES];
  logic [7:0] dst_mem [STORE_BYTES];
  logic [7:0] pat_q, msk_q, dst_q;

  logic [PITCH_W-1:0] sp, dp;
  assign sp = (32'(sp_cfg_r) > MAX_PITCH) ? PITCH_W'(MAX_PITCH) : sp_cfg_r;
  assign dp = (32'(dp_cfg_r) > MAX_PITCH) ? PITCH_W'(MAX_PITCH) : dp_cfg_r;

  logic addr_ok;
  assign addr_ok = 32'(addr_r) < STORE_BYTES;

  logic [SA_W-1:0] addr_idx;
  assign addr_idx = SA_W'(addr_r);

  // shared unit: one multiply-add per cycle
  logic [CW-1:0] mul_a, mul_b, mul_c, mul_y;
  assign mul_y = mul_a * mul_b + mul_c;

  logic [CW-1:0] sx, dx;
  assign sx = CW'(fx_r) + CW'(c_r);
  assign dx = CW'(tx_r) + CW'(c_r);

  always_comb begin
    mul_a = '0; mul_b = '0; mul_c = '0;
    unique case (state_r)
      S_FIT1: begin
        mul_a = CW'(fy_r) + CW'(h_r); mul_b = CW'(sp); mul_c = '0;
      end
      S_FIT2: begin
        mul_a = CW'(ty_r) + CW'(h_r); mul_b = CW'(dp); mul_c = '0;
      end
      S_ROWS: begin
        mul_a = CW'(fy_r) + CW'(r_r); mul_b = CW'(sp); mul_c = '0;
      end
      S_FETCH: begin
        mul_a = CW'(ty_r) + CW'(r_r); mul_b = CW'(dp); mul_c = '0;
      end
      default: ;
    endcase
  end

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  logic [7:0] merged;
  logic pix;
  always_comb begin
    pix = pat_q[sbit] ^ inv_r;
    merged = dst_q;
    if (msk_q[sbit]) merged[dbit] = pix;
  end

  logic sa_ok, da_ok;
  assign sa_ok = sa_cur < CW'(STORE_BYTES);
  assign da_ok = da_cur < CW'(STORE_BYTES);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = (in_operation == OP_STENCIL) ? S_FIT1 : S_SIMPLE;
      S_SIMPLE: state_nxt = (op_r == OP_READ_DST && addr_ok) ? S_RDWAIT : S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_FIT1: state_nxt = S_FIT2;
      S_FIT2: state_nxt = S_FIT3;
      S_FIT3: state_nxt = (bad_r || w_r == '0 || h_r == '0) ? S_DONE : S_ROWS;
      S_ROWS: state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_MERGE;
      S_MERGE: begin
        if (c_r + 10'd1 < w_r) state_nxt = S_FETCH;
        else if (r_r + 9'd1 < h_r) state_nxt = S_ROWS;
        else state_nxt = S_DONE;
      end
      S_DONE: state_nxt = out_valid_r ? S_DONE : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_cfg_r <= PITCH_W'(64);
      dp_cfg_r <= PITCH_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SRC_PITCH) sp_cfg_r <= cfg_data;
        else dp_cfg_r <= cfg_data;
      end
      if (out_acc) out_valid_r <= 1'b0;
      else if (state_r == S_DONE && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_operation; addr_r <= in_address;
      pat_r <= in_pattern_byte; msk_r <= in_mask_byte; din_r <= in_dest_byte_in;
      fx_r <= in_from_x; fy_r <= in_from_y; tx_r <= in_to_x; ty_r <= in_to_y;
      w_r <= in_rect_width; h_r <= in_rect_height; inv_r <= in_reverse_video;
      r_r <= '0; c_r <= '0;
      bad_r <= (CW'(in_from_x) + CW'(in_rect_width) > (CW'(sp) << 3))
            || (CW'(in_to_x) + CW'(in_rect_width) > (CW'(dp) << 3));
      out_data_r <= '0;
      out_status_r <= 1'b0;
    end
    unique case (state_r)
      S_SIMPLE: out_status_r <= !addr_ok;
      S_RDWAIT: out_data_r <= dst_q;
      S_FIT1: if (mul_y > CW'(STORE_BYTES)) bad_r <= 1'b1;
      S_FIT2: if (mul_y > CW'(STORE_BYTES)) bad_r <= 1'b1;
      S_FIT3: out_status_r <= bad_r;
      S_ROWS: srow_r <= mul_y;
      S_MERGE: begin
        if (c_r + 10'd1 < w_r) c_r <= c_r + 10'd1;
        else begin
          c_r <= '0; r_r <= r_r + 9'd1;
        end
      end
      default: ;
    endcase
  end

  // addresses for the current pixel
  always_comb begin
    sa_cur = srow_r + (sx >> 3);
    da_cur = mul_y + (dx >> 3);
    sbit = sx[2:0];
    dbit = dx[2:0];
  end

  logic [CW-1:0] da_hold_r;
  logic ok_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == S_FETCH) begin
      da_hold_r <= da_cur;
      ok_hold_r <= sa_ok && da_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SIMPLE && addr_ok && op_r == OP_LOAD_SRC) begin
      pat_mem[addr_idx] <= pat_r;
      msk_mem[addr_idx] <= msk_r;
    end
    if (state_r == S_FETCH) begin
      pat_q <= pat_mem[sa_cur[SA_W-1:0]];
      msk_q <= msk_mem[sa_cur[SA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SIMPLE && addr_ok && op_r == OP_LOAD_DST)
      dst_mem[addr_idx] <= din_r;
    else if (state_r == S_MERGE && ok_hold_r)
      dst_mem[da_hold_r[SA_W-1:0]] <= merged;
    if (state_r == S_SIMPLE)
      dst_q <= dst_mem[addr_idx];
    else if (state_r == S_FETCH)
      dst_q <= dst_mem[da_cur[SA_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status = out_status_r;
endmodule
`default_nettype wire

FILE: sv/mbsb_checker.sv
`default_nettype none
module mbsb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic [1:0] in_operation,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] out_read_data,
  input wire logic out_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
  a_nores: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid)
    else $error("accept with pending result");
  a_stzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == 8'd0)
    else $error("flagged result carries data");
  a_inhold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_operation))
    else $error("stalled input word changed");
endmodule
bind masked_bitmap_stencil_blit mbsb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_operation(in_operation), .out_valid(out_valid), .out_stall(out_stall),
  .out_read_data(out_read_data), .out_status(out_status)
);
`default_nettype wire
